// ----- rtl/core/adcv_pkg.sv -----
// adcv_pkg: shared types, register codes, reset values and tables for the
// decimate / crush / VCA block. No dependencies.
package adcv_pkg;

    typedef struct packed {
        logic signed [15:0] audio_in;
        logic        [15:0] envelope_level;
    } adcv_in_t;

    typedef struct packed {
        logic signed [15:0] processed_sample;
        logic        [7:0]  dac_byte;
    } adcv_out_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_DECIMATION = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RESOLUTION = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_VCA_EN     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MIX_BAL    = 3'd3;

    localparam logic [2:0]  RST_DECIMATION = 3'd6;
    localparam logic [2:0]  RST_RESOLUTION = 3'd4;
    localparam logic        RST_VCA_EN     = 1'b0;
    localparam logic [15:0] RST_MIX_BAL    = 16'h0000;

    localparam logic [15:0] FULL_SCALE = 16'hffff;
    localparam logic [15:0] DAC_OFFSET = 16'h8000;

    // decimation select codes (hold factors 24,12,6,4,3,2,1)
    localparam logic [2:0] DEC_24 = 3'd0;
    localparam logic [2:0] DEC_12 = 3'd1;
    localparam logic [2:0] DEC_6  = 3'd2;
    localparam logic [2:0] DEC_4  = 3'd3;
    localparam logic [2:0] DEC_3  = 3'd4;
    localparam logic [2:0] DEC_2  = 3'd5;

    function automatic logic [15:0] res_mask(input logic [2:0] sel);
        logic [15:0] m;
        begin
            case (sel)
                3'd0:    m = 16'hc000;
                3'd1:    m = 16'he000;
                3'd2:    m = 16'hf000;
                3'd3:    m = 16'hf800;
                3'd4:    m = 16'hff00;
                3'd5:    m = 16'hfff0;
                default: m = 16'hffff;
            endcase
            return m;
        end
    endfunction

endpackage

// ----- rtl/core/adcv_mul.sv -----
// adcv_mul: registered signed 16 x unsigned 16 multiply, floor >> 16.
// Depends on nothing but the operands; shared by both gain stages.
module adcv_mul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] a,
    input  logic        [15:0] b,
    output logic signed [15:0] y
);

    logic signed [33:0] prod;
    logic signed [15:0] y_reg;

    assign prod = 34'(a * $signed({1'b0, b}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= prod[31:16];
        end
    end

    assign y = y_reg;

endmodule

// ----- rtl/core/audio_decimate_crush_vca_to_dac.sv -----
// audio_decimate_crush_vca_to_dac: top level, sequencer around one shared multiplier.
// Depends on adcv_pkg and adcv_mul.
//
// Input channel in_valid/in_ready carries audio_in and envelope_level; output
// channel out_valid/out_ready carries processed_sample and dac_byte, one result per
// input transaction. Configuration is a write-only port (cfg_we, cfg_addr, cfg_wdata)
// that the user writes only while the block is idle; the block does not enforce this.
//
// Each transaction runs from acceptance to out_valid through capture,
// two passes through the one multiplier (held x gain, then held x mix scale),
// each with a registered product, and a load into the output register.
// in_ready is high only while the sequencer is idle, so a new transaction
// is taken only after the last one has been loaded into the output register.
// The output register parts the two sides: a result waiting for out_ready
// does not block the next input; only a second finished result stalls the
// sequencer until the first is taken.
//
// Reset clears held sample, gain, block position and restores the register
// defaults; no transaction is pending afterwards.
module audio_decimate_crush_vca_to_dac
    import adcv_pkg::*;
#(
    parameter int BLOCK_SIZE = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  adcv_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output adcv_out_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(BLOCK_SIZE);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_SIZE - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_WB1  = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]  dec_sel_reg;
    logic [2:0]  res_sel_reg;
    logic        vca_en_reg;
    logic [15:0] mix_bal_reg;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         mod3_reg, mod3_next;
    logic signed [15:0] held_reg, held_next;
    logic [15:0]        gain_reg, gain_next;
    logic [15:0]        target_reg;
    logic               out_valid_reg, out_valid_next;
    adcv_out_t          out_reg;

    logic               accept;
    logic               capture;
    logic               cnt_wrap;
    logic               mod3_zero;
    logic [15:0]        mul_b;
    logic               mul_en;
    logic signed [15:0] mul_y;
    logic signed [16:0] gain_diff;
    logic signed [16:0] gain_step;
    logic               out_free;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign cnt_wrap = (cnt_reg == CNT_LAST);
    assign mod3_zero = (mod3_reg == 2'd0);

    always_comb
    begin
        case (dec_sel_reg)
            DEC_24:  capture = (cnt_reg[2:0] == 3'd0) && mod3_zero;
            DEC_12:  capture = (cnt_reg[1:0] == 2'd0) && mod3_zero;
            DEC_6:   capture = !cnt_reg[0] && mod3_zero;
            DEC_4:   capture = (cnt_reg[1:0] == 2'd0);
            DEC_3:   capture = mod3_zero;
            DEC_2:   capture = !cnt_reg[0];
            default: capture = 1'b1;
        endcase
    end

    // shared multiplier: gain pass then mix pass
    assign mul_b  = (state_reg == S_MUL1) ? gain_reg : (FULL_SCALE - mix_bal_reg);
    assign mul_en = (state_reg == S_MUL1) || (state_reg == S_MUL2);

    adcv_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (held_reg),
        .b   (mul_b),
        .y   (mul_y)
    );

    assign gain_diff = $signed({1'b0, target_reg}) - $signed({1'b0, gain_reg});
    assign gain_step = gain_diff >>> 4;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mod3_next      = mod3_reg;
        held_next      = held_reg;
        gain_next      = gain_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (capture)
                    begin
                        held_next = $signed(in_data.audio_in & res_mask(res_sel_reg));
                    end
                    cnt_next  = cnt_wrap ? '0 : cnt_reg + 1'b1;
                    mod3_next = (cnt_wrap || mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                gain_next  = gain_reg + 16'(gain_step);
                state_next = S_WB1;
            end
            S_WB1:
            begin
                held_next  = mul_y;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_sel_reg   <= RST_DECIMATION;
            res_sel_reg   <= RST_RESOLUTION;
            vca_en_reg    <= RST_VCA_EN;
            mix_bal_reg   <= RST_MIX_BAL;
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            mod3_reg      <= 2'd0;
            held_reg      <= '0;
            gain_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_DECIMATION: dec_sel_reg <= cfg_wdata[2:0];
                    REG_RESOLUTION: res_sel_reg <= cfg_wdata[2:0];
                    REG_VCA_EN:     vca_en_reg  <= cfg_wdata[0];
                    REG_MIX_BAL:    mix_bal_reg <= cfg_wdata[15:0];
                    default:        ;
                endcase
            end
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mod3_reg      <= mod3_next;
            held_reg      <= held_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg <= vca_en_reg ? in_data.envelope_level : FULL_SCALE;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_reg.processed_sample <= mul_y;
            out_reg.dac_byte         <= 8'((DAC_OFFSET - 16'(mul_y)) >> 8);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("block position out of range");

    a_mod3_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (mod3_reg == 2'd0))
        else $error("mod-3 phase lost sync with block position");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MUL1) && !in_ready)
        else $error("accepted transaction did not start the sequence");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> out_valid && in_ready)
        else $error("finished result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result overwritten while output stalled");

endmodule
